[hdl/kect_pkg.sv]
`timescale 1ns / 1ps

package kect_pkg;

  localparam int unsigned NARROW_ENTRIES_DEF = 4096;
  localparam int unsigned WIDE_ENTRIES_DEF = 256;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned LANES = 8;

  localparam logic [7:0] MARKER = 8'd255;
  localparam logic [7:0] PROMOTE_AT = 8'd254;
  localparam logic [31:0] WIDE_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] ST_NARROW = 2'd0;
  localparam logic [1:0] ST_WIDE = 2'd1;
  localparam logic [1:0] ST_DROP = 2'd2;

  typedef struct packed {
    logic vld;
    logic [KEY_W-1:0] key;
    logic [7:0] cov;
    logic [LANES-1:0][7:0] ec;
  } narrow_row_t;

  typedef struct packed {
    logic vld;
    logic [KEY_W-1:0] key;
    logic [31:0] cov;
    logic [LANES-1:0][31:0] ec;
  } wide_row_t;

endpackage

[hdl/kmer_edge_count_table.sv]
`timescale 1ns / 1ps

// K-mer coverage and edge counter over a narrow and a wide hash table.
// Input channel: in_valid/in_stall with in_key and in_edge_bits. Result
// channel: out_valid/out_stall with out_status, out_coverage, out_in_wide;
// one result item per input item, in order.
// One item is processed at a time. Table sizes are powers of two, so the home
// slots are the low key bits, registered in kect_mod. Each narrow slot probed
// takes a memory read and a compare, and so does each wide slot probed if the
// entry is promoted; then the output register is loaded, and only then can the
// next item be accepted. After reset both tables are swept clear, one row a
// cycle, until every row of the larger table is written; in_stall is high
// meanwhile. A stalled result holds in the output register; the next item is
// accepted while it waits, and its result waits until the register frees.

module kmer_edge_count_table #(
  parameter int unsigned NARROW_ENTRIES = kect_pkg::NARROW_ENTRIES_DEF,
  parameter int unsigned WIDE_ENTRIES = kect_pkg::WIDE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [kect_pkg::KEY_W-1:0] in_key,
  input  logic [7:0]                 in_edge_bits,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [31:0]                out_coverage,
  output logic                       out_in_wide
);

  localparam int unsigned NI = $clog2(NARROW_ENTRIES);
  localparam int unsigned WI = $clog2(WIDE_ENTRIES);
  localparam int unsigned MAXE = (NARROW_ENTRIES > WIDE_ENTRIES) ? NARROW_ENTRIES
                                                                 : WIDE_ENTRIES;
  localparam int unsigned CI = $clog2(MAXE);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_MOD, S_NRD, S_NCHK, S_WRD, S_WCHK, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [CI-1:0] clr_r, clr_nxt;
  logic [kect_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [7:0] edges_r, edges_nxt;
  logic [NI-1:0] n_idx_r, n_idx_nxt, n_cnt_r, n_cnt_nxt;
  logic [WI-1:0] w_idx_r, w_idx_nxt, w_cnt_r, w_cnt_nxt;
  kect_pkg::narrow_row_t nrow_r, nrow_nxt;
  logic [1:0] res_st_r, res_st_nxt;
  logic [31:0] res_cov_r, res_cov_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [31:0] out_cov_r, out_cov_nxt;
  logic out_wide_r, out_wide_nxt;

  kect_pkg::narrow_row_t nmem [NARROW_ENTRIES];
  kect_pkg::wide_row_t wmem [WIDE_ENTRIES];
  kect_pkg::narrow_row_t nrd_r, n_wd;
  kect_pkg::wide_row_t wrd_r, w_wd;
  logic n_we, w_we;
  logic [NI-1:0] n_wa;
  logic [WI-1:0] w_wa;

  logic mod_start, mod_done;
  logic [NI-1:0] home_n;
  logic [WI-1:0] home_w;

  kect_mod #(
    .NARROW_ENTRIES(NARROW_ENTRIES),
    .WIDE_ENTRIES(WIDE_ENTRIES)
  ) u_mod (
    .clk(clk),
    .rst_n(rst_n),
    .start(mod_start),
    .key(key_r),
    .done(mod_done),
    .rem_n(home_n),
    .rem_w(home_w)
  );

  always_ff @(posedge clk) begin
    if (n_we) nmem[n_wa] <= n_wd;
    nrd_r <= nmem[n_idx_r];
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_wa] <= w_wd;
    wrd_r <= wmem[w_idx_r];
  end

  always_comb begin
    kect_pkg::narrow_row_t nb;
    kect_pkg::wide_row_t wb;
    logic promote;
    state_nxt = state_r;
    clr_nxt = clr_r;
    key_nxt = key_r;
    edges_nxt = edges_r;
    n_idx_nxt = n_idx_r;
    n_cnt_nxt = n_cnt_r;
    w_idx_nxt = w_idx_r;
    w_cnt_nxt = w_cnt_r;
    nrow_nxt = nrow_r;
    res_st_nxt = res_st_r;
    res_cov_nxt = res_cov_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_cov_nxt = out_cov_r;
    out_wide_nxt = out_wide_r;
    mod_start = 1'b0;
    n_we = 1'b0;
    n_wa = n_idx_r;
    n_wd = '0;
    w_we = 1'b0;
    w_wa = w_idx_r;
    w_wd = '0;
    nb = nrd_r;
    wb = wrd_r;
    promote = 1'b0;

    case (state_r)
      S_CLR: begin
        n_wa = clr_r[NI-1:0];
        w_wa = clr_r[WI-1:0];
        n_we = ({1'b0, clr_r} < (CI+1)'(NARROW_ENTRIES));
        w_we = ({1'b0, clr_r} < (CI+1)'(WIDE_ENTRIES));
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CI'(MAXE - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          key_nxt = in_key;
          edges_nxt = in_edge_bits;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        mod_start = !mod_done && (n_cnt_r == '1) && (w_cnt_r == '1);
        n_cnt_nxt = '0;
        w_cnt_nxt = '0;
        if (mod_done) begin
          n_idx_nxt = home_n;
          w_idx_nxt = home_w;
          state_nxt = S_NRD;
        end
      end
      S_NRD: state_nxt = S_NCHK;
      S_NCHK: begin
        if (!nrd_r.vld || nrd_r.key == key_r) begin
          if (!nrd_r.vld) begin
            nb = '0;
            nb.vld = 1'b1;
            nb.key = key_r;
          end
          promote = (nb.cov == kect_pkg::MARKER) || (nb.cov == kect_pkg::PROMOTE_AT);
          for (int l = 0; l < int'(kect_pkg::LANES); l++)
            if (nb.ec[l] == kect_pkg::PROMOTE_AT) promote = 1'b1;
          nrow_nxt = nb;
          if (!promote) begin
            for (int l = 0; l < int'(kect_pkg::LANES); l++)
              n_wd.ec[l] = nb.ec[l] + 8'(edges_r[l]);
            n_wd.vld = 1'b1;
            n_wd.key = key_r;
            n_wd.cov = nb.cov + 8'd1;
            n_we = 1'b1;
            res_st_nxt = kect_pkg::ST_NARROW;
            res_cov_nxt = 32'(n_wd.cov);
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_WRD;
          end
        end else if (n_cnt_r == NI'(NARROW_ENTRIES - 1)) begin
          res_st_nxt = kect_pkg::ST_DROP;
          res_cov_nxt = '0;
          state_nxt = S_OUT;
        end else begin
          n_cnt_nxt = n_cnt_r + 1'b1;
          n_idx_nxt = (n_idx_r == NI'(NARROW_ENTRIES - 1)) ? '0 : n_idx_r + 1'b1;
          state_nxt = S_NRD;
        end
      end
      S_WRD: state_nxt = S_WCHK;
      S_WCHK: begin
        if (!wrd_r.vld || wrd_r.key == key_r) begin
          if (!wrd_r.vld) begin
            wb.vld = 1'b1;
            wb.key = key_r;
            wb.cov = 32'(nrow_r.cov);
            for (int l = 0; l < int'(kect_pkg::LANES); l++)
              wb.ec[l] = 32'(nrow_r.ec[l]);
            n_wd = nrow_r;
            n_wd.cov = kect_pkg::MARKER;
            n_we = 1'b1;
          end
          w_wd = wb;
          for (int l = 0; l < int'(kect_pkg::LANES); l++)
            if (edges_r[l] && wb.ec[l] != kect_pkg::WIDE_MAX) w_wd.ec[l] = wb.ec[l] + 32'd1;
          if (wb.cov != kect_pkg::WIDE_MAX) w_wd.cov = wb.cov + 32'd1;
          w_we = 1'b1;
          res_st_nxt = kect_pkg::ST_WIDE;
          res_cov_nxt = w_wd.cov;
          state_nxt = S_OUT;
        end else if (w_cnt_r == WI'(WIDE_ENTRIES - 1)) begin
          res_st_nxt = kect_pkg::ST_DROP;
          res_cov_nxt = '0;
          state_nxt = S_OUT;
        end else begin
          w_cnt_nxt = w_cnt_r + 1'b1;
          w_idx_nxt = (w_idx_r == WI'(WIDE_ENTRIES - 1)) ? '0 : w_idx_r + 1'b1;
          state_nxt = S_WRD;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = res_st_r;
          out_cov_nxt = res_cov_r;
          out_wide_nxt = (res_st_r == kect_pkg::ST_WIDE);
          n_cnt_nxt = '1;
          w_cnt_nxt = '1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      n_cnt_r <= '1;
      w_cnt_r <= '1;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      n_cnt_r <= n_cnt_nxt;
      w_cnt_r <= w_cnt_nxt;
    end
    key_r <= key_nxt;
    edges_r <= edges_nxt;
    n_idx_r <= n_idx_nxt;
    w_idx_r <= w_idx_nxt;
    nrow_r <= nrow_nxt;
    res_st_r <= res_st_nxt;
    res_cov_r <= res_cov_nxt;
    out_status_r <= out_status_nxt;
    out_cov_r <= out_cov_nxt;
    out_wide_r <= out_wide_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_coverage = out_cov_r;
  assign out_in_wide = out_wide_r;

endmodule

[hdl/kect_mod.sv]
`timescale 1ns / 1ps

module kect_mod #(
  parameter int unsigned NARROW_ENTRIES = kect_pkg::NARROW_ENTRIES_DEF,
  parameter int unsigned WIDE_ENTRIES = kect_pkg::WIDE_ENTRIES_DEF,
  localparam int unsigned NI = $clog2(NARROW_ENTRIES),
  localparam int unsigned WI = $clog2(WIDE_ENTRIES)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [kect_pkg::KEY_W-1:0] key,
  output logic                       done,
  output logic [NI-1:0]              rem_n,
  output logic [WI-1:0]              rem_w
);

  logic done_r;
  logic [NI-1:0] rn_r;
  logic [WI-1:0] rw_r;

  // table sizes are powers of two: the home slot is the low key bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
    if (start) begin
      rn_r <= key[NI-1:0];
      rw_r <= key[WI-1:0];
    end
  end

  assign done = done_r;
  assign rem_n = rn_r;
  assign rem_w = rw_r;

endmodule

[tb/sv/kmer_edge_count_table_test.sv]
`timescale 1ns / 1ps

module kmer_edge_count_table_test;

  localparam int NE = kect_pkg::NARROW_ENTRIES_DEF;
  localparam int NW = kect_pkg::WIDE_ENTRIES_DEF;
  localparam int NL = kect_pkg::LANES;
  localparam int IDLE_LIMIT = 40000;
  localparam int HOLD_CYCLES = 500;

  typedef struct {
    logic [63:0] key;
    logic [7:0] edges;
  } kmer_t;

  typedef struct {
    logic [1:0] status;
    logic [31:0] cov;
    logic wide;
  } count_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [63:0] in_key = '0;
  logic [7:0] in_edge_bits = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] out_status;
  logic [31:0] out_coverage;
  logic out_in_wide;

  kmer_edge_count_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_key(in_key), .in_edge_bits(in_edge_bits),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_coverage(out_coverage), .out_in_wide(out_in_wide)
  );

  always #5 clk = ~clk;

  // shadow tables
  bit n_vld [NE];
  logic [63:0] n_key [NE];
  logic [7:0] n_cov [NE];
  logic [7:0] n_ec [NE][NL];
  bit w_vld [NW];
  logic [63:0] w_key [NW];
  logic [31:0] w_cov [NW];
  logic [31:0] w_ec [NW][NL];

  kmer_t pending [$];
  count_t counts_due [$];
  int errors = 0;
  int sent = 0;
  int got = 0;
  int idle = 0;

  function automatic count_t count_kmer(logic [63:0] key, logic [7:0] eb);
    count_t r;
    int ns;
    int ws;
    bit hit;
    bit promote;
    int idx;
    r = '{kect_pkg::ST_DROP, 32'd0, 1'b0};
    ns = -1;
    hit = 0;
    for (int i = 0; i < NE; i++) begin
      idx = int'((key % 64'(NE) + 64'(i)) % 64'(NE));
      if (!n_vld[idx]) begin
        ns = idx;
        break;
      end
      if (n_key[idx] == key) begin
        ns = idx;
        hit = 1;
        break;
      end
    end
    if (ns < 0) return r;
    if (!hit) begin
      n_vld[ns] = 1;
      n_key[ns] = key;
      n_cov[ns] = 8'd0;
      for (int l = 0; l < NL; l++) n_ec[ns][l] = 8'd0;
    end
    promote = (n_cov[ns] == kect_pkg::MARKER) || (n_cov[ns] == kect_pkg::PROMOTE_AT);
    for (int l = 0; l < NL; l++)
      if (n_ec[ns][l] == kect_pkg::PROMOTE_AT) promote = 1;
    if (!promote) begin
      for (int l = 0; l < NL; l++) n_ec[ns][l] = n_ec[ns][l] + 8'(eb[l]);
      n_cov[ns] = n_cov[ns] + 8'd1;
      r = '{kect_pkg::ST_NARROW, 32'(n_cov[ns]), 1'b0};
      return r;
    end
    ws = -1;
    hit = 0;
    for (int i = 0; i < NW; i++) begin
      idx = int'((key % 64'(NW) + 64'(i)) % 64'(NW));
      if (!w_vld[idx]) begin
        ws = idx;
        break;
      end
      if (w_key[idx] == key) begin
        ws = idx;
        hit = 1;
        break;
      end
    end
    if (ws < 0) return r;
    if (!hit) begin
      w_vld[ws] = 1;
      w_key[ws] = key;
      w_cov[ws] = 32'(n_cov[ns]);
      for (int l = 0; l < NL; l++) w_ec[ws][l] = 32'(n_ec[ns][l]);
      n_cov[ns] = kect_pkg::MARKER;
    end
    for (int l = 0; l < NL; l++)
      if (eb[l] && w_ec[ws][l] != kect_pkg::WIDE_MAX) w_ec[ws][l] = w_ec[ws][l] + 32'd1;
    if (w_cov[ws] != kect_pkg::WIDE_MAX) w_cov[ws] = w_cov[ws] + 32'd1;
    r = '{kect_pkg::ST_WIDE, w_cov[ws], 1'b1};
    return r;
  endfunction

  task automatic add_kmer(logic [63:0] key, logic [7:0] eb);
    kmer_t it;
    it.key = key;
    it.edges = eb;
    pending.insert(pending.size(), it);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver
  int in_gap = 0;
  kmer_t nxt;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        counts_due.insert(counts_due.size(), count_kmer(in_key, in_edge_bits));
        sent++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 0;
        end else if (pending.size() > 0) begin
          nxt = pending.pop_front();
          in_valid <= 1;
          in_key <= nxt.key;
          in_edge_bits <= nxt.edges;
          in_gap = ((sent / 150) % 3 == 1) ? 0 : pick_gap();
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  int out_hold = 0;
  bit held = 0;
  count_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got++;
        if (counts_due.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          want = counts_due.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d got %0d", want.status, out_status);
            errors++;
          end
          if (out_coverage !== want.cov) begin
            $error("coverage: expected %0d got %0d", want.cov, out_coverage);
            errors++;
          end
          if (out_in_wide !== want.wide) begin
            $error("in_wide: expected %0d got %0d", want.wide, out_in_wide);
            errors++;
          end
        end
      end
      if (!held && got == 300) begin
        held = 1;
        out_hold = HOLD_CYCLES;
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1;
      end else if ((got / 200) % 3 == 2) begin
        out_stall <= 0;
      end else begin
        out_stall <= (pick_gap() != 0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle <= 0;
    else idle <= idle + 1;
    if (idle >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  logic [63:0] hot [3];
  logic [63:0] pool [40];
  int r;

  initial begin
    for (int i = 0; i < 3; i++) hot[i] = {$urandom, $urandom};
    for (int i = 0; i < 40; i++) pool[i] = {$urandom, $urandom};

    // extremes, home collisions, wrap-around past the last slot
    add_kmer(64'd0, 8'h00);
    add_kmer(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    add_kmer(64'd4096, 8'h0F);
    add_kmer(64'd8192, 8'hF0);
    add_kmer(64'd4095, 8'h55);
    add_kmer(64'd4095 + 64'd4096, 8'hAA);
    add_kmer(64'd0, 8'hFF);
    add_kmer(64'd8192, 8'h01);
    add_kmer(64'h8000_0000_0000_0000, 8'h80);
    add_kmer(64'h5555_5555_5555_5555, 8'h3C);
    add_kmer(64'hAAAA_AAAA_AAAA_AAAA, 8'hC3);
    add_kmer(64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
    for (int i = 0; i < 3; i++) add_kmer(hot[i], 8'($urandom));
    for (int i = 0; i < 40; i++) add_kmer(pool[i], 8'($urandom));
    add_kmer({$urandom, $urandom}, 8'hFF);
    add_kmer(64'd12288, 8'h00);

    // hot keys get promoted, by edge counts and by coverage
    for (int i = 0; i < 1090; i++) begin
      r = $urandom_range(0, 29);
      if (i % 110 == 55) add_kmer({$urandom, $urandom}, 8'($urandom));
      else if (r < 9) add_kmer(hot[0], 8'hFF);
      else if (r < 17) add_kmer(hot[1], 8'h00);
      else if (r < 20) add_kmer(hot[2], 8'($urandom));
      else add_kmer(pool[$urandom_range(0, 39)], 8'($urandom));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    while (pending.size() > 0 || in_valid || counts_due.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
